@@ design/asa_pkg.sv @@
// Shared types and constants for the accelerator slot allocator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package asa_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int ID_BITS_DEF = 16;
    localparam int LOAD_W      = 16;
    localparam int CNT_W       = 5;
    localparam int MASK_W      = 16;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 48;

    // Command codes
    localparam logic [1:0] CMD_ASSIGN  = 2'd0;
    localparam logic [1:0] CMD_RELEASE = 2'd1;

    // Controls shared by every slot cell
    typedef struct packed {
        logic shift;
        logic clear;
    } cell_ctl_t;

    // Sequencer states, one-hot
    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_COUNT  = 6'b000010,
        ST_UPDATE = 6'b000100,
        ST_SCAN   = 6'b001000,
        ST_DIV    = 6'b010000,
        ST_DONE   = 6'b100000
    } state_t;

endpackage

@@ design/asa_cell.sv @@
// One slot cell of the rotating slot ring: occupied bit, owner, load, duplicate flag.
// Depends on asa_pkg for the shared cell controls.
`timescale 1ns / 1ps

module asa_cell
    import asa_pkg::*;
#(
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cell_ctl_t          ctl,
    input  logic               mark_en,
    input  logic [ID_BITS-1:0] probe_id,
    input  logic               in_occ,
    input  logic [ID_BITS-1:0] in_owner,
    input  logic [LOAD_W-1:0]  in_load,
    input  logic               in_dup,
    output logic               occ,
    output logic [ID_BITS-1:0] owner,
    output logic [LOAD_W-1:0]  load,
    output logic               dup,
    output logic               dup_out
);

    logic               occ_reg;
    logic               dup_reg;
    logic [ID_BITS-1:0] owner_reg;
    logic [LOAD_W-1:0]  load_reg;

    // Flag this slot as a repeat of the owner now at the head
    assign dup_out = dup_reg | (mark_en & occ_reg & (owner_reg == probe_id));

    // Control bits: clear on reconfiguration, take the neighbor on shift
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            occ_reg <= 1'b0;
            dup_reg <= 1'b0;
        end
        else if (ctl.clear)
        begin
            occ_reg <= 1'b0;
            dup_reg <= 1'b0;
        end
        else if (ctl.shift)
        begin
            occ_reg <= in_occ;
            dup_reg <= in_dup;
        end
    end

    // Payload moves with the ring
    always_ff @(posedge clk)
    begin
        if (ctl.shift)
        begin
            owner_reg <= in_owner;
            load_reg  <= in_load;
        end
    end

    assign occ   = occ_reg;
    assign owner = owner_reg;
    assign load  = load_reg;
    assign dup   = dup_reg;

endmodule

@@ design/asa_divider.sv @@
// Restoring divider, one quotient bit per cycle, for the mean load.
// Depends on asa_pkg for the load width.
`timescale 1ns / 1ps

module asa_divider
    import asa_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    input  logic [LOAD_W+$clog2(SLOTS+1)-1:0] dividend,
    input  logic [$clog2(SLOTS+1)-1:0]        divisor,
    output logic                              busy,
    output logic [LOAD_W-1:0]                 quotient
);

    localparam int NW = $clog2(SLOTS + 1);
    localparam int SW = LOAD_W + NW;
    localparam int IW = $clog2(SW + 1);

    logic [SW-1:0] quo_reg, quo_next;
    logic [NW:0]   rem_reg, rem_next;
    logic [NW-1:0] div_reg;
    logic [IW-1:0] cnt_reg, cnt_next;
    logic          busy_reg, busy_next;
    logic [NW+1:0] trial;

    // One restoring step
    always_comb
    begin
        trial     = {rem_reg, quo_reg[SW-1]};
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        if (start)
        begin
            quo_next  = dividend;
            rem_next  = '0;
            cnt_next  = IW'(SW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= (NW+2)'(div_reg))
            begin
                rem_next = (NW+1)'(trial - (NW+2)'(div_reg));
                quo_next = {quo_reg[SW-2:0], 1'b1};
            end
            else
            begin
                rem_next = trial[NW:0];
                quo_next = {quo_reg[SW-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == IW'(1))
                busy_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        if (start)
            div_reg <= divisor;
    end

    assign busy     = busy_reg;
    assign quotient = quo_reg[LOAD_W-1:0];

endmodule

@@ design/accelerator_slot_allocator_core.sv @@
// Accelerator slot allocator: first-fit slot assignment and release over a
// rotating ring of slot cells, with occupancy and load statistics.
//
// Usage: commands arrive on the s_axis group (tdata), one result per command
// leaves on the m_axis group. cfg_we with cfg_wdata sets the slot count and
// clears all slots; write it only while the block is idle.
// Timing: each command rotates the ring through a free-count pass, an update
// pass and a statistics-scan pass, then runs the divide step (one quotient
// bit per cycle) and loads the output register; the next command is taken
// once the result is loaded. The ring rotates one slot past the head logic
// per cycle. One command is in work at a time.
// Reset: all slots free, slot count 16, no result pending.
// Stall: a result holds in the output register while m_axis_tready is low;
// the next command may be fully processed and then waits until the register
// drains.
`timescale 1ns / 1ps

module accelerator_slot_allocator_core
    import asa_pkg::*;
#(
    parameter int SLOTS   = SLOTS_DEF,
    parameter int ID_BITS = ID_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CNT_W-1:0]       cfg_wdata,     // slot_count
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // command[1:0], job_id[17:2], slots_wanted[22:18], job_load[38:23]
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // accepted[0], granted_mask[16:1], freed_count[21:17], free_count[26:22],
    // loaded_jobs[31:27], mean_load[47:32]
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int NW = $clog2(SLOTS + 1);
    localparam int KW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int SW = LOAD_W + NW;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]   slot_count_reg;
    logic [1:0]         cmd_reg;
    logic [ID_BITS-1:0] id_reg;
    logic [CNT_W-1:0]   want_reg;
    logic [LOAD_W-1:0]  load_reg;
    logic [KW-1:0]      k_reg, k_next;
    logic [NW-1:0]      free_reg, free_next;
    logic [NW-1:0]      freed_reg, freed_next;
    logic [NW-1:0]      jobs_reg, jobs_next;
    logic [CNT_W-1:0]   rem_reg, rem_next;
    logic [MASK_W-1:0]  grant_reg, grant_next;
    logic [SW-1:0]      sum_reg, sum_next;
    logic               ok_reg, ok_next;

    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [NW-1:0] n_act;
    logic          in_fire, out_load, k_last, k_in;
    cell_ctl_t     ctl;

    // Ring wiring
    logic               c_occ   [SLOTS];
    logic [ID_BITS-1:0] c_owner [SLOTS];
    logic [LOAD_W-1:0]  c_load  [SLOTS];
    logic               c_dup   [SLOTS];
    logic               c_dupo  [SLOTS];
    logic               c_mark  [SLOTS];
    logic               h_occ, h_dup;
    logic [ID_BITS-1:0] h_owner;
    logic [LOAD_W-1:0]  h_load;

    logic          div_start, div_busy;
    logic [LOAD_W-1:0] div_q;

    // Effective slot count, saturated to the ring length; zero counts as one
    always_comb
    begin
        if (slot_count_reg == '0)
            n_act = NW'(1);
        else if (32'(slot_count_reg) > SLOTS)
            n_act = NW'(SLOTS);
        else
            n_act = NW'(slot_count_reg);
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_fire       = s_axis_tvalid & s_axis_tready;
    assign k_last        = (32'(k_reg) == SLOTS - 1);
    assign k_in          = ((NW+1)'(k_reg) < (NW+1)'(n_act));
    assign ctl.shift     = (state_reg == ST_COUNT) | (state_reg == ST_UPDATE) |
                           (state_reg == ST_SCAN);
    assign ctl.clear     = cfg_we;

    // Slot ring: each cell takes its upper neighbor, the last takes the head
    for (genvar p = 0; p < SLOTS; p++)
    begin : g_cell
        if (p == 0)
        begin : g_first
            assign c_mark[p] = 1'b0;
        end
        else
        begin : g_rest
            assign c_mark[p] = (state_reg == ST_SCAN) & c_occ[0] &
                               ((32'(k_reg) + p) <= (SLOTS - 1));
        end
        if (p == SLOTS - 1)
        begin : g_last
            asa_cell #(.ID_BITS(ID_BITS)) u_cell (
                .clk(clk), .rst_n(rst_n), .ctl(ctl), .mark_en(c_mark[p]),
                .probe_id(c_owner[0]),
                .in_occ(h_occ), .in_owner(h_owner), .in_load(h_load), .in_dup(h_dup),
                .occ(c_occ[p]), .owner(c_owner[p]), .load(c_load[p]), .dup(c_dup[p]),
                .dup_out(c_dupo[p])
            );
        end
        else
        begin : g_mid
            asa_cell #(.ID_BITS(ID_BITS)) u_cell (
                .clk(clk), .rst_n(rst_n), .ctl(ctl), .mark_en(c_mark[p]),
                .probe_id(c_owner[0]),
                .in_occ(c_occ[p+1]), .in_owner(c_owner[p+1]), .in_load(c_load[p+1]),
                .in_dup(c_dupo[p+1]),
                .occ(c_occ[p]), .owner(c_owner[p]), .load(c_load[p]), .dup(c_dup[p]),
                .dup_out(c_dupo[p])
            );
        end
    end

    // Head logic: process the slot at cell 0 and write it back at the tail
    always_comb
    begin
        state_next = state_reg;
        k_next     = k_reg;
        free_next  = free_reg;
        freed_next = freed_reg;
        jobs_next  = jobs_reg;
        rem_next   = rem_reg;
        grant_next = grant_reg;
        sum_next   = sum_reg;
        ok_next    = ok_reg;
        h_occ      = c_occ[0];
        h_owner    = c_owner[0];
        h_load     = c_load[0];
        h_dup      = 1'b0;
        div_start  = 1'b0;
        out_load   = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = ST_COUNT;
                    k_next     = '0;
                    free_next  = '0;
                    freed_next = '0;
                    jobs_next  = '0;
                    grant_next = '0;
                    sum_next   = '0;
                end
            end
            ST_COUNT:
            begin
                h_dup = c_dup[0];
                if (k_in && !c_occ[0])
                    free_next = free_reg + 1'b1;
                k_next = k_reg + 1'b1;
                if (k_last)
                begin
                    k_next     = '0;
                    state_next = ST_UPDATE;
                    ok_next    = (cmd_reg != CMD_ASSIGN) ||
                                 ((NW+CNT_W)'(want_reg) <= (NW+CNT_W)'(free_next));
                end
            end
            ST_UPDATE:
            begin
                if (cmd_reg == CMD_ASSIGN && ok_reg && k_in && !c_occ[0] && rem_reg != '0)
                begin
                    h_occ    = 1'b1;
                    h_owner  = id_reg;
                    h_load   = load_reg;
                    rem_next = rem_reg - 1'b1;
                    if (32'(k_reg) < MASK_W)
                        grant_next[4'(k_reg)] = 1'b1;
                end
                else if (cmd_reg == CMD_RELEASE && k_in && c_occ[0] && c_owner[0] == id_reg)
                begin
                    h_occ      = 1'b0;
                    h_owner    = '0;
                    h_load     = '0;
                    freed_next = freed_reg + 1'b1;
                end
                k_next = k_reg + 1'b1;
                if (k_last)
                begin
                    k_next     = '0;
                    free_next  = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (k_in)
                begin
                    if (!c_occ[0])
                        free_next = free_reg + 1'b1;
                    else
                    begin
                        sum_next = sum_reg + SW'(c_load[0]);
                        if (!c_dup[0])
                            jobs_next = jobs_reg + 1'b1;
                    end
                end
                k_next = k_reg + 1'b1;
                if (k_last)
                begin
                    k_next     = '0;
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (!div_busy)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Divide the full sum, including the slot at the head on the last scan cycle
    asa_divider #(.SLOTS(SLOTS)) u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(sum_next),
        .divisor(n_act), .busy(div_busy), .quotient(div_q)
    );

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            slot_count_reg <= CNT_W'(16);
            out_valid_reg  <= 1'b0;
            k_reg          <= '0;
        end
        else
        begin
            state_reg <= state_next;
            k_reg     <= k_next;
            if (cfg_we)
                slot_count_reg <= cfg_wdata;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Command fields, counters and the result register
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= s_axis_tdata[1:0];
            id_reg   <= ID_BITS'(s_axis_tdata[17:2]);
            want_reg <= s_axis_tdata[22:18];
            rem_reg  <= s_axis_tdata[22:18];
            load_reg <= s_axis_tdata[38:23];
        end
        else
            rem_reg <= rem_next;
        free_reg  <= free_next;
        freed_reg <= freed_next;
        jobs_reg  <= jobs_next;
        grant_reg <= grant_next;
        sum_reg   <= sum_next;
        ok_reg    <= ok_next;
        if (out_load)
            out_data_reg <= {div_q, CNT_W'(jobs_reg), CNT_W'(free_reg),
                             CNT_W'(freed_reg), grant_reg, ok_reg};
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

`ifndef NO_ASSERTIONS
    // A refused assign reports no granted slot
    a_refused_no_grant: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[16:1] == '0)
        else $error("refused command reports granted slots");

    // The divider is never running while a command may be taken
    a_idle_div: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready |-> !div_busy)
        else $error("divider busy while idle");

    // The ring comes back aligned at the end of the free-count pass
    a_pass_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_COUNT && k_last |=> state_reg == ST_UPDATE && k_reg == '0)
        else $error("ring pass misaligned");
`endif

endmodule
